### rtl/lam_pkg.sv
// Shared types, widths and pipeline depths for the look-at matrix unit.
package lam_pkg;

  localparam int IN_W      = 32;             // Q16.16 input component
  localparam int COMP_W    = 16;             // Q2.14 output component
  localparam int FRAC      = 14;
  localparam int NORM_IN_W = 34;             // widest vector component fed to a normalizer
  localparam int MAG_W     = NORM_IN_W;
  localparam int POS_W     = $clog2(MAG_W);
  localparam int LEAD_POS  = 29;             // leading one lands here after alignment
  localparam int SMAG_W    = LEAD_POS + 1;
  localparam int SQ_W      = 2 * SMAG_W;
  localparam int SUM_W     = 64;
  localparam int SQRT_BITS = SUM_W / 2;
  localparam int SQRT_PER  = 2;              // root bits resolved per stage
  localparam int SQRT_STAGES = SQRT_BITS / SQRT_PER;
  localparam int REM_W     = SQRT_BITS + 3;
  localparam int LEN_W     = SQRT_BITS;
  localparam int Q_BITS    = 16;
  localparam int DIV_PER   = 2;              // quotient bits resolved per stage
  localparam int DIV_STAGES = Q_BITS / DIV_PER;
  localparam int NUM_W     = SMAG_W + FRAC + 1;
  localparam int PROD_W    = 2 * COMP_W;

  localparam int NORM_LAT  = 7 + SQRT_STAGES + DIV_STAGES;
  localparam int CROSS_LAT = 2;
  localparam int STEP_LAT  = CROSS_LAT + NORM_LAT;
  localparam int TOTAL_LAT = 2 + NORM_LAT + 2 * STEP_LAT;

  typedef struct packed {
    logic signed [IN_W-1:0] pos_x;
    logic signed [IN_W-1:0] pos_y;
    logic signed [IN_W-1:0] pos_z;
    logic signed [IN_W-1:0] target_x;
    logic signed [IN_W-1:0] target_y;
    logic signed [IN_W-1:0] target_z;
    logic signed [IN_W-1:0] up_x;
    logic signed [IN_W-1:0] up_y;
    logic signed [IN_W-1:0] up_z;
  } req_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] row_x_0;
    logic signed [COMP_W-1:0] row_x_1;
    logic signed [COMP_W-1:0] row_x_2;
    logic signed [COMP_W-1:0] row_y_0;
    logic signed [COMP_W-1:0] row_y_1;
    logic signed [COMP_W-1:0] row_y_2;
    logic signed [COMP_W-1:0] row_z_0;
    logic signed [COMP_W-1:0] row_z_1;
    logic signed [COMP_W-1:0] row_z_2;
    logic                     degenerate;
  } rsp_t;

  typedef logic [2:0][NORM_IN_W-1:0] nin_vec_t;
  typedef logic [2:0][COMP_W-1:0]    unit_vec_t;

  typedef struct packed {
    logic vld;
    logic zero;
  } nstat_t;

endpackage

### rtl/lam_norm.sv
// Pipelined three-component vector normalizer producing a Q2.14 unit vector.
module lam_norm (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               vld,
  input  lam_pkg::nin_vec_t  vec,
  output lam_pkg::nstat_t    stat,
  output lam_pkg::unit_vec_t unit
);

  typedef struct packed {
    logic [lam_pkg::LEN_W-1:0]             res;
    logic [lam_pkg::REM_W-1:0]             rem;
    logic [lam_pkg::SUM_W-1:0]             sum;
    logic [2:0][lam_pkg::SMAG_W-1:0]       mag;
    logic [2:0]                            neg;
    logic                                  zero;
  } sq_t;

  typedef struct packed {
    logic [lam_pkg::LEN_W-1:0]             len;
    logic [2:0][lam_pkg::LEN_W-1:0]        r;
    logic [2:0][lam_pkg::Q_BITS-1:0]       lq;
    logic [2:0]                            neg;
    logic                                  zero;
  } dv_t;

  // Stage A: magnitudes and signs.
  logic                                a_vld;
  logic [2:0][lam_pkg::MAG_W-1:0]      a_mag;
  logic [2:0]                          a_neg;
  // Stage B: leading-one position of the largest magnitude.
  logic                                b_vld;
  logic [2:0][lam_pkg::MAG_W-1:0]      b_mag;
  logic [2:0]                          b_neg;
  logic                                b_zero;
  logic [lam_pkg::POS_W-1:0]           b_pos;
  logic [lam_pkg::POS_W-1:0]           b_pos_next;
  // Stage C: aligned magnitudes.
  logic                                c_vld;
  logic [2:0][lam_pkg::SMAG_W-1:0]     c_mag;
  logic [2:0][lam_pkg::SMAG_W-1:0]     c_mag_next;
  logic [2:0]                          c_neg;
  logic                                c_zero;
  // Stage D: squares.
  logic                                d_vld;
  logic [2:0][lam_pkg::SQ_W-1:0]       d_sq;
  logic [2:0][lam_pkg::SMAG_W-1:0]     d_mag;
  logic [2:0]                          d_neg;
  logic                                d_zero;
  // Stage E: sum of squares.
  logic                                e_vld;
  logic [lam_pkg::SUM_W-1:0]           e_sum;
  logic [2:0][lam_pkg::SMAG_W-1:0]     e_mag;
  logic [2:0]                          e_neg;
  logic                                e_zero;

  sq_t  sq_q   [lam_pkg::SQRT_STAGES];
  logic sq_vld [lam_pkg::SQRT_STAGES];

  logic dv0_vld;
  dv_t  dv0;
  dv_t  dv0_next;
  dv_t  dv_q   [lam_pkg::DIV_STAGES];
  logic dv_vld [lam_pkg::DIV_STAGES];

  logic               o_vld;
  logic               o_zero;
  lam_pkg::unit_vec_t o_unit;
  lam_pkg::unit_vec_t o_unit_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      c_vld <= 1'b0;
      d_vld <= 1'b0;
      e_vld <= 1'b0;
    end else if (en) begin
      a_vld <= vld;
      b_vld <= a_vld;
      c_vld <= b_vld;
      d_vld <= c_vld;
      e_vld <= d_vld;
    end
  end

  always_comb begin
    logic [lam_pkg::MAG_W-1:0] orv;
    orv = a_mag[0] | a_mag[1] | a_mag[2];
    b_pos_next = '0;
    for (int i = 0; i < lam_pkg::MAG_W; i++) begin
      if (orv[i]) begin
        b_pos_next = lam_pkg::POS_W'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (b_pos >= lam_pkg::POS_W'(lam_pkg::LEAD_POS)) begin
        c_mag_next[i] = lam_pkg::SMAG_W'(b_mag[i] >> (b_pos - lam_pkg::POS_W'(lam_pkg::LEAD_POS)));
      end else begin
        c_mag_next[i] = lam_pkg::SMAG_W'(b_mag[i] << (lam_pkg::POS_W'(lam_pkg::LEAD_POS) - b_pos));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a_neg[i] <= vec[i][lam_pkg::MAG_W-1];
        a_mag[i] <= vec[i][lam_pkg::MAG_W-1] ? (lam_pkg::MAG_W'(0) - vec[i]) : vec[i];
        d_sq[i]  <= lam_pkg::SQ_W'(c_mag[i]) * lam_pkg::SQ_W'(c_mag[i]);
      end
      b_mag  <= a_mag;
      b_neg  <= a_neg;
      b_zero <= ((a_mag[0] | a_mag[1] | a_mag[2]) == '0);
      b_pos  <= b_pos_next;
      c_mag  <= c_mag_next;
      c_neg  <= b_neg;
      c_zero <= b_zero;
      d_mag  <= c_mag;
      d_neg  <= c_neg;
      d_zero <= c_zero;
      e_sum  <= lam_pkg::SUM_W'(d_sq[0]) + lam_pkg::SUM_W'(d_sq[1]) + lam_pkg::SUM_W'(d_sq[2]);
      e_mag  <= d_mag;
      e_neg  <= d_neg;
      e_zero <= d_zero;
    end
  end

  // Integer square root, two result bits per stage, most significant first.
  for (genvar j = 0; j < lam_pkg::SQRT_STAGES; j++) begin : g_sqrt
    sq_t  src;
    sq_t  nxt;
    logic src_vld;
    if (j == 0) begin : g_head
      assign src     = {lam_pkg::LEN_W'(0), lam_pkg::REM_W'(0), e_sum, e_mag, e_neg, e_zero};
      assign src_vld = e_vld;
    end else begin : g_body
      assign src     = sq_q[j-1];
      assign src_vld = sq_vld[j-1];
    end

    always_comb begin
      logic [lam_pkg::REM_W-1:0] rem_w;
      logic [lam_pkg::REM_W-1:0] trial;
      int                        bp;
      nxt = src;
      for (int k = 0; k < lam_pkg::SQRT_PER; k++) begin
        bp    = 2 * (lam_pkg::SQRT_BITS - 1 - (j * lam_pkg::SQRT_PER + k));
        rem_w = {nxt.rem[lam_pkg::REM_W-3:0], src.sum[bp +: 2]};
        trial = lam_pkg::REM_W'({nxt.res, 2'b01});
        if (rem_w >= trial) begin
          nxt.rem = rem_w - trial;
          nxt.res = {nxt.res[lam_pkg::LEN_W-2:0], 1'b1};
        end else begin
          nxt.rem = rem_w;
          nxt.res = {nxt.res[lam_pkg::LEN_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_vld[j] <= 1'b0;
      end else if (en) begin
        sq_vld[j] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_q[j] <= nxt;
      end
    end
  end

  // Division setup: numerator is the aligned magnitude in Q14 plus half the length.
  always_comb begin
    logic [lam_pkg::NUM_W-1:0] num;
    dv0_next.len  = sq_q[lam_pkg::SQRT_STAGES-1].res;
    dv0_next.neg  = sq_q[lam_pkg::SQRT_STAGES-1].neg;
    dv0_next.zero = sq_q[lam_pkg::SQRT_STAGES-1].zero;
    for (int i = 0; i < 3; i++) begin
      num = (lam_pkg::NUM_W'(sq_q[lam_pkg::SQRT_STAGES-1].mag[i]) << lam_pkg::FRAC)
          + lam_pkg::NUM_W'(sq_q[lam_pkg::SQRT_STAGES-1].res >> 1);
      dv0_next.r[i]  = lam_pkg::LEN_W'(num[lam_pkg::NUM_W-1:lam_pkg::Q_BITS]);
      dv0_next.lq[i] = num[lam_pkg::Q_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv0_vld <= 1'b0;
    end else if (en) begin
      dv0_vld <= sq_vld[lam_pkg::SQRT_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv0 <= dv0_next;
    end
  end

  // Restoring division; quotient bits shift in where numerator bits shift out.
  for (genvar j = 0; j < lam_pkg::DIV_STAGES; j++) begin : g_div
    dv_t  src;
    dv_t  nxt;
    logic src_vld;
    if (j == 0) begin : g_head
      assign src     = dv0;
      assign src_vld = dv0_vld;
    end else begin : g_body
      assign src     = dv_q[j-1];
      assign src_vld = dv_vld[j-1];
    end

    always_comb begin
      logic [lam_pkg::LEN_W:0] t;
      logic                    qb;
      nxt = src;
      for (int k = 0; k < lam_pkg::DIV_PER; k++) begin
        for (int i = 0; i < 3; i++) begin
          t  = {nxt.r[i], nxt.lq[i][lam_pkg::Q_BITS-1]};
          qb = (t >= {1'b0, src.len});
          if (qb) begin
            t = t - {1'b0, src.len};
          end
          nxt.r[i]  = t[lam_pkg::LEN_W-1:0];
          nxt.lq[i] = {nxt.lq[i][lam_pkg::Q_BITS-2:0], qb};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[j] <= 1'b0;
      end else if (en) begin
        dv_vld[j] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_q[j] <= nxt;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_q[lam_pkg::DIV_STAGES-1].zero) begin
        o_unit_next[i] = '0;
      end else if (dv_q[lam_pkg::DIV_STAGES-1].neg[i]) begin
        o_unit_next[i] = lam_pkg::COMP_W'(0) - dv_q[lam_pkg::DIV_STAGES-1].lq[i];
      end else begin
        o_unit_next[i] = dv_q[lam_pkg::DIV_STAGES-1].lq[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
    end else if (en) begin
      o_vld <= dv_vld[lam_pkg::DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_unit <= o_unit_next;
      o_zero <= dv_q[lam_pkg::DIV_STAGES-1].zero;
    end
  end

  assign stat.vld  = o_vld;
  assign stat.zero = o_zero;
  assign unit      = o_unit;

endmodule

### rtl/lam_cross.sv
// Two-stage exact cross product of two Q2.14 unit vectors.
module lam_cross (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               vld,
  input  lam_pkg::unit_vec_t a,
  input  lam_pkg::unit_vec_t b,
  output logic               out_vld,
  output lam_pkg::nin_vec_t  res
);

  logic                               p_vld;
  logic signed [lam_pkg::PROD_W-1:0]  p [6];
  lam_pkg::nin_vec_t                  r;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld   <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      p_vld   <= vld;
      out_vld <= p_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p[0] <= $signed(a[1]) * $signed(b[2]);
      p[1] <= $signed(a[2]) * $signed(b[1]);
      p[2] <= $signed(a[2]) * $signed(b[0]);
      p[3] <= $signed(a[0]) * $signed(b[2]);
      p[4] <= $signed(a[0]) * $signed(b[1]);
      p[5] <= $signed(a[1]) * $signed(b[0]);
      r[0] <= lam_pkg::NORM_IN_W'(p[0]) - lam_pkg::NORM_IN_W'(p[1]);
      r[1] <= lam_pkg::NORM_IN_W'(p[2]) - lam_pkg::NORM_IN_W'(p[3]);
      r[2] <= lam_pkg::NORM_IN_W'(p[4]) - lam_pkg::NORM_IN_W'(p[5]);
    end
  end

  assign res = r;

endmodule

### rtl/look_at_matrix_axis_fixed.sv
// Top level of the up-axis-fixed look-at rotation unit.
//
// The request channel (req_valid, req_stall, req) carries one transaction per
// object: position, target and up vector, all signed Q16.16. The response
// channel (rsp_valid, rsp_stall, rsp) returns the three rotation rows X, Y and
// Z as Q2.14 unit vectors plus a degenerate flag set when any vector to be
// normalized had zero length; its outputs are then zero.
// A transaction is accepted at a clock edge where valid is high and stall low.
// The unit takes a new transaction every cycle while req_stall is low and
// returns responses in order of acceptance. Each of the four normalizers is
// 31 stages deep, set by its integer square root (two root bits per stage)
// followed by its restoring divider (two quotient bits per stage).
// The pipeline advances as one: when a response is held stalled, every stage
// holds, and req_stall is raised in the same cycle; when the output register
// is empty or being taken, all stages move, so nothing is lost or repeated.
// A synchronous reset clears every valid bit, so no response appears until
// new requests flow through the full pipeline depth.
module look_at_matrix_axis_fixed (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  lam_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output lam_pkg::rsp_t rsp
);

  localparam int YD = 2 * lam_pkg::STEP_LAT;
  localparam int XD = lam_pkg::STEP_LAT;

  logic en;

  // Input register and difference stage.
  logic              in_vld;
  lam_pkg::req_t     in_d;
  logic              df_vld;
  lam_pkg::nin_vec_t df_d;
  lam_pkg::nin_vec_t df_up;

  lam_pkg::nstat_t    nd_stat;
  lam_pkg::unit_vec_t nd_unit;
  lam_pkg::nstat_t    ny_stat;
  lam_pkg::unit_vec_t ny_unit;
  lam_pkg::nstat_t    nx_stat;
  lam_pkg::unit_vec_t nx_unit;
  lam_pkg::nstat_t    nz_stat;
  lam_pkg::unit_vec_t nz_unit;

  logic              cx_vld;
  lam_pkg::nin_vec_t cx_res;
  logic              cz_vld;
  lam_pkg::nin_vec_t cz_res;

  // Delay lines that keep Y, X and the running degenerate flag aligned.
  lam_pkg::unit_vec_t ydl    [YD];
  logic               dydeg  [XD];
  lam_pkg::unit_vec_t xdl    [XD];
  logic               xdeg   [XD];

  // The whole pipeline holds only while a finished response waits.
  assign en        = !rsp_valid || !rsp_stall;
  assign req_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
      df_vld <= 1'b0;
    end else if (en) begin
      in_vld <= req_valid;
      df_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_d     <= req;
      df_d[0]  <= lam_pkg::NORM_IN_W'(in_d.target_x) - lam_pkg::NORM_IN_W'(in_d.pos_x);
      df_d[1]  <= lam_pkg::NORM_IN_W'(in_d.target_y) - lam_pkg::NORM_IN_W'(in_d.pos_y);
      df_d[2]  <= lam_pkg::NORM_IN_W'(in_d.target_z) - lam_pkg::NORM_IN_W'(in_d.pos_z);
      df_up[0] <= lam_pkg::NORM_IN_W'(in_d.up_x);
      df_up[1] <= lam_pkg::NORM_IN_W'(in_d.up_y);
      df_up[2] <= lam_pkg::NORM_IN_W'(in_d.up_z);
    end
  end

  // Look direction and up axis are normalized side by side.
  lam_norm u_norm_d (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .vld  (df_vld),
    .vec  (df_d),
    .stat (nd_stat),
    .unit (nd_unit)
  );

  lam_norm u_norm_y (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .vld  (df_vld),
    .vec  (df_up),
    .stat (ny_stat),
    .unit (ny_unit)
  );

  // Side axis: Y cross D.
  lam_cross u_cross_x (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .vld     (nd_stat.vld && ny_stat.vld),
    .a       (ny_unit),
    .b       (nd_unit),
    .out_vld (cx_vld),
    .res     (cx_res)
  );

  lam_norm u_norm_x (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .vld  (cx_vld),
    .vec  (cx_res),
    .stat (nx_stat),
    .unit (nx_unit)
  );

  // Forward axis: X cross Y, with Y taken from the middle of its delay line.
  lam_cross u_cross_z (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .vld     (nx_stat.vld),
    .a       (nx_unit),
    .b       (ydl[XD-1]),
    .out_vld (cz_vld),
    .res     (cz_res)
  );

  lam_norm u_norm_z (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .vld  (cz_vld),
    .vec  (cz_res),
    .stat (nz_stat),
    .unit (nz_unit)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      ydl[0]   <= ny_unit;
      dydeg[0] <= nd_stat.zero || ny_stat.zero;
      xdl[0]   <= nx_unit;
      xdeg[0]  <= dydeg[XD-1] || nx_stat.zero;
      for (int i = 1; i < YD; i++) begin
        ydl[i] <= ydl[i-1];
      end
      for (int i = 1; i < XD; i++) begin
        dydeg[i] <= dydeg[i-1];
        xdl[i]   <= xdl[i-1];
        xdeg[i]  <= xdeg[i-1];
      end
    end
  end

  // The last normalizer's output register doubles as the response register.
  assign rsp_valid      = nz_stat.vld;
  assign rsp.row_x_0    = xdl[XD-1][0];
  assign rsp.row_x_1    = xdl[XD-1][1];
  assign rsp.row_x_2    = xdl[XD-1][2];
  assign rsp.row_y_0    = ydl[YD-1][0];
  assign rsp.row_y_1    = ydl[YD-1][1];
  assign rsp.row_y_2    = ydl[YD-1][2];
  assign rsp.row_z_0    = nz_unit[0];
  assign rsp.row_z_1    = nz_unit[1];
  assign rsp.row_z_2    = nz_unit[2];
  assign rsp.degenerate = xdeg[XD-1] || nz_stat.zero;

endmodule

### rtl/lam_chk.sv
// Port-level checker for the look-at matrix unit, bound to the top level.
module lam_chk (
  input logic          clk,
  input logic          rst,
  input logic          req_stall,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input lam_pkg::rsp_t rsp
);

  // A stalled response stays put.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // Requests are held back only while a finished response waits.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> rsp_valid && rsp_stall)
    else $error("request stalled without a waiting response");

  // A zero-length vector anywhere forces the side and forward axes to zero.
  a_degenerate_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.degenerate |->
      rsp.row_x_0 == '0 && rsp.row_x_1 == '0 && rsp.row_x_2 == '0 &&
      rsp.row_z_0 == '0 && rsp.row_z_1 == '0 && rsp.row_z_2 == '0)
    else $error("degenerate response with nonzero axes");

  // Up axis components never exceed one in Q2.14.
  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |->
      rsp.row_y_0 <= 16'sd16384 && rsp.row_y_0 >= -16'sd16384 &&
      rsp.row_y_1 <= 16'sd16384 && rsp.row_y_1 >= -16'sd16384 &&
      rsp.row_y_2 <= 16'sd16384 && rsp.row_y_2 >= -16'sd16384)
    else $error("up axis component out of range");

endmodule

bind look_at_matrix_axis_fixed lam_chk u_lam_chk (.*);

### tb/tb_look_at_matrix_axis_fixed.sv
// Self-checking testbench for the up-axis-fixed look-at rotation unit.
module tb_look_at_matrix_axis_fixed;

  timeunit 1ns;
  timeprecision 1ps;

  // The predictor: normalization of a wide vector to a Q2.14 unit vector,
  // exactly as the unit does it. Returns 1 when the vector has zero length.
  function automatic bit unit_of(input longint v[3], output longint u[3]);
    logic [63:0] mag[3];
    bit neg[3];
    logic [63:0] m, s, len, half, rem, root, bt;
    m = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = v[i] < 0;
      mag[i] = neg[i] ? 64'(-v[i]) : 64'(v[i]);
      if (mag[i] > m) m = mag[i];
    end
    if (m == 0) begin
      for (int i = 0; i < 3; i++) u[i] = 0;
      return 1'b1;
    end
    while (m >= 64'd1 << 30) begin
      m = m >> 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
    end
    while (m < 64'd1 << 29) begin
      m = m << 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
    end
    s = 0;
    for (int i = 0; i < 3; i++) s += mag[i] * mag[i];
    // Bitwise integer square root.
    rem = s;
    root = 0;
    bt = 64'd1 << 62;
    while (bt > rem) bt = bt >> 2;
    while (bt != 0) begin
      if (rem >= root + bt) begin
        rem -= root + bt;
        root = (root >> 1) + bt;
      end else begin
        root = root >> 1;
      end
      bt = bt >> 2;
    end
    len = root;
    half = len >> 1;
    for (int i = 0; i < 3; i++) begin
      u[i] = longint'(((mag[i] << 14) + half) / len);
      if (neg[i]) u[i] = -u[i];
    end
    return 1'b0;
  endfunction

  function automatic void cross_of(input longint a[3], input longint b[3],
                                   output longint r[3]);
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  function automatic lam_pkg::rsp_t look_at_rows(input lam_pkg::req_t q);
    longint d[3], up[3], dn[3], yn[3], xc[3], xn[3], zc[3], zn[3];
    bit deg;
    lam_pkg::rsp_t r;
    d[0] = longint'(q.target_x) - longint'(q.pos_x);
    d[1] = longint'(q.target_y) - longint'(q.pos_y);
    d[2] = longint'(q.target_z) - longint'(q.pos_z);
    up[0] = q.up_x;
    up[1] = q.up_y;
    up[2] = q.up_z;
    deg = unit_of(d, dn);
    deg |= unit_of(up, yn);
    cross_of(yn, dn, xc);
    deg |= unit_of(xc, xn);
    cross_of(xn, yn, zc);
    deg |= unit_of(zc, zn);
    r.row_x_0 = lam_pkg::COMP_W'(xn[0]);
    r.row_x_1 = lam_pkg::COMP_W'(xn[1]);
    r.row_x_2 = lam_pkg::COMP_W'(xn[2]);
    r.row_y_0 = lam_pkg::COMP_W'(yn[0]);
    r.row_y_1 = lam_pkg::COMP_W'(yn[1]);
    r.row_y_2 = lam_pkg::COMP_W'(yn[2]);
    r.row_z_0 = lam_pkg::COMP_W'(zn[0]);
    r.row_z_1 = lam_pkg::COMP_W'(zn[1]);
    r.row_z_2 = lam_pkg::COMP_W'(zn[2]);
    r.degenerate = deg;
    return r;
  endfunction

  // Scoreboard: holds expected rows in order of acceptance.
  class rows_board;
    lam_pkg::rsp_t pending[$];
    int errors;

    function void note_request(lam_pkg::req_t q);
      pending.push_back(look_at_rows(q));
    endfunction

    function void check_rows(lam_pkg::rsp_t got);
      lam_pkg::rsp_t exp;
      if (pending.size() == 0) begin
        $error("unexpected response transaction");
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.row_x_0 !== exp.row_x_0) begin
        $error("row_x_0 expected %0d got %0d", exp.row_x_0, got.row_x_0); errors++;
      end
      if (got.row_x_1 !== exp.row_x_1) begin
        $error("row_x_1 expected %0d got %0d", exp.row_x_1, got.row_x_1); errors++;
      end
      if (got.row_x_2 !== exp.row_x_2) begin
        $error("row_x_2 expected %0d got %0d", exp.row_x_2, got.row_x_2); errors++;
      end
      if (got.row_y_0 !== exp.row_y_0) begin
        $error("row_y_0 expected %0d got %0d", exp.row_y_0, got.row_y_0); errors++;
      end
      if (got.row_y_1 !== exp.row_y_1) begin
        $error("row_y_1 expected %0d got %0d", exp.row_y_1, got.row_y_1); errors++;
      end
      if (got.row_y_2 !== exp.row_y_2) begin
        $error("row_y_2 expected %0d got %0d", exp.row_y_2, got.row_y_2); errors++;
      end
      if (got.row_z_0 !== exp.row_z_0) begin
        $error("row_z_0 expected %0d got %0d", exp.row_z_0, got.row_z_0); errors++;
      end
      if (got.row_z_1 !== exp.row_z_1) begin
        $error("row_z_1 expected %0d got %0d", exp.row_z_1, got.row_z_1); errors++;
      end
      if (got.row_z_2 !== exp.row_z_2) begin
        $error("row_z_2 expected %0d got %0d", exp.row_z_2, got.row_z_2); errors++;
      end
      if (got.degenerate !== exp.degenerate) begin
        $error("degenerate expected %0d got %0d", exp.degenerate, got.degenerate);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  lam_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  lam_pkg::rsp_t rsp;

  rows_board board = new();
  bit calm = 1'b0;   // once set, neither side idles any more
  int num_random = 1900;

  always #6 clk = ~clk;

  look_at_matrix_axis_fixed DUT (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  // Response side: check each accepted transaction and stall in short bursts.
  int stall_left = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && !rsp_stall) board.check_rows(rsp);
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        rsp_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left <= $urandom_range(0, 3);
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  // Presents one request, holds it until accepted, then may idle for a burst.
  task automatic send(input lam_pkg::req_t q);
    int gap;
    req <= q;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    board.note_request(q);
    if (!calm && $urandom_range(0, 5) == 0) begin
      req_valid <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap - 1) @(posedge clk);
      @(posedge clk);
    end
  endtask

  function automatic logic [31:0] rand_comp(input int kind);
    case (kind)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 8191)) - 4096);
      2: return 32'h8000_0000 + $urandom_range(0, 3);
      3: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      default: return 32'($signed($urandom_range(0, 600000)) - 300000);
    endcase
  endfunction

  task automatic send_vectors(input logic [31:0] p[3], input logic [31:0] t[3],
                              input logic [31:0] u[3]);
    lam_pkg::req_t q;
    q = {p[0], p[1], p[2], t[0], t[1], t[2], u[0], u[1], u[2]};
    send(q);
  endtask

  initial begin
    logic [31:0] p[3], t[3], u[3];
    int k;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes and the zero-length special cases.
    send_vectors('{0, 0, 0}, '{32'h0001_0000, 0, 0}, '{0, 32'h0001_0000, 0});
    send_vectors('{5, 6, 7}, '{5, 6, 7}, '{0, 32'h0001_0000, 0});       // target at pos
    send_vectors('{0, 0, 0}, '{0, 0, 32'h0001_0000}, '{0, 0, 0});       // zero up
    send_vectors('{0, 0, 0}, '{0, 32'h0003_0000, 0}, '{0, 32'h0001_0000, 0}); // up along D
    send_vectors('{0, 0, 0}, '{0, 0, 1}, '{1, 0, 0});                   // tiny vectors
    send_vectors('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
                 '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
                 '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    send_vectors('{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF},
                 '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000},
                 '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    send_vectors('{32'hFFFF_FFFF, 0, 0}, '{0, 32'hFFFF_FFFF, 0}, '{0, 0, 32'hFFFF_FFFF});
    send_vectors('{0, 0, 0}, '{32'hFFFF_0000, 0, 0}, '{0, 0, 32'h8000_0000});
    send_vectors('{0, 0, 0}, '{32'h0000_1000, 32'h0000_1000, 0},
                 '{32'h0000_1001, 32'h0000_1000, 0});                   // nearly parallel

    // Hold off until the pipeline has drained completely.
    req_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);

    // Random part: mixed magnitudes, with some degenerate cases mixed in.
    for (int n = 0; n < num_random; n++) begin
      if (n == num_random - 200) calm = 1'b1;
      k = $urandom_range(0, 4);
      for (int i = 0; i < 3; i++) begin
        p[i] = rand_comp(k);
        t[i] = rand_comp($urandom_range(0, 4));
        u[i] = rand_comp($urandom_range(0, 4));
      end
      case ($urandom_range(0, 19))
        0: t = p;
        1: u = '{0, 0, 0};
        2: for (int i = 0; i < 3; i++) u[i] = t[i] - p[i];
        default: ;
      endcase
      send_vectors(p, t, u);
    end
    req_valid <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (lam_pkg::TOTAL_LAT + 20) @(posedge clk);
    if (board.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #(12ns * 200000);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
